@@ rtl/kss_pkg.sv @@
// Shared constants, types and status codes for the two-set rank selector.
// No dependencies; every other file refers to these by scoped names.
package kss_pkg;

	localparam int SET_DEPTH = 256;
	localparam int CHAIN_LEN = 2 * SET_DEPTH;
	localparam int VALUE_W   = 31;
	localparam int RANK_W    = 10;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = $clog2(SET_DEPTH + 1);
	localparam int TOTAL_W   = $clog2(CHAIN_LEN + 1);

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANK = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd2;

	typedef logic [VALUE_W-1:0] value_t;

	// Per-cycle command broadcast to every cell of the sorting chain
	typedef struct packed {
		logic ins;
		logic shift;
	} chain_ctrl_t;

endpackage

@@ rtl/kth_smallest_of_two_sets.sv @@
// Rank selector over two sets of 31-bit unsigned values. Each accepted request inserts its
// value into one sorted chain of 2*SET_DEPTH cells, so loading runs at one request per
// cycle while in_stall is low; a set already holding SET_DEPTH values drops the value and
// marks overflow. The request flagged last_item closes the job: the chain then shifts toward
// its head rank-1 times (not at all on an error) and the head is reported. in_stall stays high
// from the closing request until the result is loaded into the output register; a result
// held by out_stall keeps in_stall high until the output register frees.
// Result status: 0 ok, 1 rank is zero or beyond the element count, 2 a set overflowed (takes
// priority); kth_value is zero unless status is 0.
// Depends on kss_pkg and kss_chain.
module kth_smallest_of_two_sets (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rank_we,
	input  logic [kss_pkg::RANK_W-1:0]    rank_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [kss_pkg::VALUE_W-1:0]   value,
	input  logic                          set_select,
	input  logic                          last_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [kss_pkg::VALUE_W-1:0]   kth_value,
	output logic [kss_pkg::STATUS_W-1:0]  status
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SEEK = 1'b1;

	logic                           state_q;
	logic [kss_pkg::RANK_W-1:0]     rank_q;
	logic [kss_pkg::COUNT_W-1:0]    first_cnt_q;
	logic [kss_pkg::COUNT_W-1:0]    second_cnt_q;
	logic                           ovf_q;
	logic [kss_pkg::TOTAL_W-1:0]    seek_cnt_q;
	logic [kss_pkg::STATUS_W-1:0]   status_q;
	logic                           out_valid_q;
	kss_pkg::value_t                kth_value_q;
	logic [kss_pkg::STATUS_W-1:0]   out_status_q;

	logic                           accept;
	logic                           sel_full;
	logic                           do_ins;
	logic [kss_pkg::TOTAL_W-1:0]    total;
	logic [kss_pkg::TOTAL_W-1:0]    total_next;
	logic [kss_pkg::STATUS_W-1:0]   status_next;
	logic                           load_out;
	kss_pkg::chain_ctrl_t           ctrl;
	kss_pkg::value_t                head;

	assign in_stall = (state_q == S_SEEK);
	assign accept   = in_valid && !in_stall;
	assign sel_full = set_select ? (second_cnt_q == kss_pkg::COUNT_W'(kss_pkg::SET_DEPTH))
	                             : (first_cnt_q == kss_pkg::COUNT_W'(kss_pkg::SET_DEPTH));
	assign do_ins   = accept && !sel_full;

	assign total      = kss_pkg::TOTAL_W'(first_cnt_q) + kss_pkg::TOTAL_W'(second_cnt_q);
	assign total_next = total + kss_pkg::TOTAL_W'(do_ins);

	always_comb begin
		if (ovf_q || sel_full) begin
			status_next = kss_pkg::STATUS_OVF;
		end else if (rank_q == '0 || int'(rank_q) > int'(total_next)) begin
			status_next = kss_pkg::STATUS_RANK;
		end else begin
			status_next = kss_pkg::STATUS_OK;
		end
	end

	assign load_out   = (state_q == S_SEEK) && (seek_cnt_q == '0) && (!out_valid_q || !out_stall);
	assign ctrl.ins   = do_ins;
	assign ctrl.shift = (state_q == S_SEEK) && (seek_cnt_q != '0);

	kss_chain u_chain (
		.clk   (clk),
		.ctrl  (ctrl),
		.value (value),
		.total (total),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= kss_pkg::RANK_W'(1);
		end else if (rank_we) begin
			rank_q <= rank_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			ovf_q        <= 1'b0;
			seek_cnt_q   <= '0;
			status_q     <= kss_pkg::STATUS_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (last_item) begin
							// close the job: counts restart, chain keeps its contents for the seek
							first_cnt_q  <= '0;
							second_cnt_q <= '0;
							ovf_q        <= 1'b0;
							status_q     <= status_next;
							seek_cnt_q   <= (status_next == kss_pkg::STATUS_OK)
							                ? kss_pkg::TOTAL_W'(rank_q - kss_pkg::RANK_W'(1))
							                : '0;
							state_q      <= S_SEEK;
						end else if (sel_full) begin
							ovf_q <= 1'b1;
						end else if (set_select) begin
							second_cnt_q <= second_cnt_q + kss_pkg::COUNT_W'(1);
						end else begin
							first_cnt_q <= first_cnt_q + kss_pkg::COUNT_W'(1);
						end
					end
				end
				S_SEEK: begin
					if (seek_cnt_q != '0) begin
						seek_cnt_q <= seek_cnt_q - kss_pkg::TOTAL_W'(1);
					end else if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kth_value_q  <= (status_q == kss_pkg::STATUS_OK) ? head : '0;
			out_status_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign kth_value = kth_value_q;
	assign status    = out_status_q;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != kss_pkg::STATUS_OK) |-> (kth_value == '0))
		else $error("error result carries a nonzero value");

	a_job_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_item) |=>
		(first_cnt_q == '0 && second_cnt_q == '0 && !ovf_q))
		else $error("job end did not clear the counts");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(first_cnt_q) <= kss_pkg::SET_DEPTH && int'(second_cnt_q) <= kss_pkg::SET_DEPTH))
		else $error("set count beyond capacity");

	a_seek_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK && seek_cnt_q != '0) |=>
		(state_q == S_SEEK && seek_cnt_q == $past(seek_cnt_q) - kss_pkg::TOTAL_W'(1)))
		else $error("seek counter did not advance");

	a_seek_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEEK && status_q == kss_pkg::STATUS_OK) |->
		(int'(seek_cnt_q) < kss_pkg::CHAIN_LEN))
		else $error("seek distance beyond the chain");
`endif

endmodule

@@ rtl/kss_cell.sv @@
// One cell of the sorted insertion chain: holds a single element.
// Depends on kss_pkg for the value type and the chain command struct.
module kss_cell (
	input  logic                clk,
	input  kss_pkg::chain_ctrl_t ctrl,
	input  kss_pkg::value_t     value,
	input  logic                occ,
	input  logic                left_gt,
	input  kss_pkg::value_t     left_q,
	input  kss_pkg::value_t     right_q,
	output logic                gt,
	output kss_pkg::value_t     q
);

	kss_pkg::value_t elem_q;

	// New value belongs at or before this cell
	assign gt = !occ || (value < elem_q);
	assign q  = elem_q;

	// Shift takes the right element; insert takes the left if it moves, else the new
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			elem_q <= right_q;
		end else if (ctrl.ins && gt) begin
			elem_q <= left_gt ? left_q : value;
		end
	end

endmodule

@@ rtl/kss_chain.sv @@
// Row of kss_cell instances forming an ascending sorted list of all loaded elements.
// Depends on kss_pkg and kss_cell; occupancy of each cell follows the element count.
module kss_chain (
	input  logic                         clk,
	input  kss_pkg::chain_ctrl_t         ctrl,
	input  kss_pkg::value_t              value,
	input  logic [kss_pkg::TOTAL_W-1:0]  total,
	output kss_pkg::value_t              head
);

	kss_pkg::value_t q   [kss_pkg::CHAIN_LEN];
	logic            gt  [kss_pkg::CHAIN_LEN];

	for (genvar i = 0; i < kss_pkg::CHAIN_LEN; i++) begin : g_cell
		logic            occ;
		logic            left_gt;
		kss_pkg::value_t left_q;
		kss_pkg::value_t right_q;

		assign occ = total > kss_pkg::TOTAL_W'(i);

		if (i == 0) begin : g_first
			assign left_gt = 1'b0;
			assign left_q  = value;
		end else begin : g_mid
			assign left_gt = gt[i-1];
			assign left_q  = q[i-1];
		end

		if (i == kss_pkg::CHAIN_LEN - 1) begin : g_last
			assign right_q = q[i];
		end else begin : g_body
			assign right_q = q[i+1];
		end

		kss_cell u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.value   (value),
			.occ     (occ),
			.left_gt (left_gt),
			.left_q  (left_q),
			.right_q (right_q),
			.gt      (gt[i]),
			.q       (q[i])
		);
	end

	assign head = q[0];

endmodule
